// ===== rtl/pru_pkg.sv =====
// Shared types and constants for the PNG row unfilter.
package pru_pkg;

    // Filter-type byte values as they appear in the stream
    localparam logic [7:0] PNG_FILTER_NONE  = 8'd0;
    localparam logic [7:0] PNG_FILTER_SUB   = 8'd1;
    localparam logic [7:0] PNG_FILTER_UP    = 8'd2;
    localparam logic [7:0] PNG_FILTER_AVG   = 8'd3;
    localparam logic [7:0] PNG_FILTER_PAETH = 8'd4;

    // Internal filter code carried with each row byte
    localparam logic [2:0] FILT_NONE    = 3'd0;
    localparam logic [2:0] FILT_SUB     = 3'd1;
    localparam logic [2:0] FILT_UP      = 3'd2;
    localparam logic [2:0] FILT_AVG     = 3'd3;
    localparam logic [2:0] FILT_PAETH   = 3'd4;
    localparam logic [2:0] FILT_UNKNOWN = 3'd5;

    // Config register indexes
    localparam logic [1:0] REG_PIXEL_COLUMNS  = 2'd0;
    localparam logic [1:0] REG_COLOR_COUNT    = 2'd1;
    localparam logic [1:0] REG_COMPONENT_BITS = 2'd2;

    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [2:0] filt;
        logic       first_row;
        logic       first_pixel;
        logic       last;
    } item_ctl_t;

endpackage

// ===== rtl/pru_front.sv =====
// Front end: takes stream bytes, tracks row position, classifies row bytes.
module pru_front
    import pru_pkg::*;
#(
    parameter int POS_W = 13,
    parameter int LEN_W = 14,
    parameter int BPP_W = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_data_byte,
    input  logic             s_stream_start,
    input  logic [LEN_W-1:0] row_len,
    input  logic [BPP_W-1:0] pixel_bytes,
    input  logic             hold,
    input  logic             q_full,
    output logic             push,
    output logic [7:0]       push_byte,
    output logic [POS_W-1:0] push_pos,
    output item_ctl_t        push_ctl
);

    localparam int CMP_W = LEN_W + 1;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [2:0]       filt_reg, filt_next;
    logic             awaiting_reg, awaiting_next;
    logic             first_row_reg, first_row_next;

    logic             accept;
    logic             is_filter;
    logic             len_zero;
    logic             row_end;
    logic [CMP_W-1:0] pos_inc;
    logic [2:0]       byte_code;

    assign s_ready  = !hold && !q_full;
    assign accept   = s_valid && s_ready;
    assign len_zero = (row_len == '0);
    assign is_filter = awaiting_reg || s_stream_start || len_zero;
    assign pos_inc  = CMP_W'(pos_reg) + CMP_W'(1);
    assign row_end  = (pos_inc >= CMP_W'(row_len));

    always_comb begin
        case (s_data_byte)
            PNG_FILTER_NONE:  byte_code = FILT_NONE;
            PNG_FILTER_SUB:   byte_code = FILT_SUB;
            PNG_FILTER_UP:    byte_code = FILT_UP;
            PNG_FILTER_AVG:   byte_code = FILT_AVG;
            PNG_FILTER_PAETH: byte_code = FILT_PAETH;
            default:          byte_code = FILT_UNKNOWN;
        endcase
    end

    assign push                 = accept && !is_filter;
    assign push_byte            = s_data_byte;
    assign push_pos             = pos_reg;
    assign push_ctl.filt        = filt_reg;
    assign push_ctl.first_row   = first_row_reg;
    assign push_ctl.first_pixel = (CMP_W'(pos_reg) < CMP_W'(pixel_bytes));
    assign push_ctl.last        = row_end;

    always_comb begin
        pos_next       = pos_reg;
        filt_next      = filt_reg;
        awaiting_next  = awaiting_reg;
        first_row_next = first_row_reg;
        if (accept) begin
            if (s_stream_start) begin
                first_row_next = 1'b1;
            end
            if (is_filter) begin
                filt_next     = byte_code;
                pos_next      = '0;
                awaiting_next = len_zero;
            end else if (row_end) begin
                awaiting_next  = 1'b1;
                first_row_next = 1'b0;
                pos_next       = '0;
            end else begin
                pos_next = pos_inc[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            filt_reg      <= FILT_NONE;
            awaiting_reg  <= 1'b1;
            first_row_reg <= 1'b1;
        end else begin
            pos_reg       <= pos_next;
            filt_reg      <= filt_next;
            awaiting_reg  <= awaiting_next;
            first_row_reg <= first_row_next;
        end
    end

endmodule

// ===== rtl/pru_queue.sv =====
// Short FIFO between the front end and the reconstruction back end.
module pru_queue
    import pru_pkg::*;
#(
    parameter int DATA_W = 27
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] head_data,
    output logic              not_empty,
    output logic              full
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign head_data = slot_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

// ===== rtl/pru_back.sv =====
// Back end: above-row memory, predictor arithmetic and output register.
module pru_back
    import pru_pkg::*;
#(
    parameter int MAX_ROW_BYTES   = 8192,
    parameter int MAX_PIXEL_BYTES = 8,
    parameter int POS_W           = 13,
    parameter int PB_W            = 3
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  logic [7:0]       q_byte,
    input  logic [POS_W-1:0] q_pos,
    input  item_ctl_t        q_ctl,
    output logic             pop,
    input  logic [PB_W-1:0]  hist_idx,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_row_last,
    output logic             m_filter_unknown
);

    logic [7:0]       row_mem [MAX_ROW_BYTES];
    logic [7:0]       left_hist_reg [MAX_PIXEL_BYTES];
    logic [7:0]       upleft_hist_reg [MAX_PIXEL_BYTES];

    logic             a_valid_reg, a_valid_next;
    item_ctl_t        a_ctl_reg;
    logic [7:0]       a_byte_reg;
    logic [POS_W-1:0] a_pos_reg;
    logic [7:0]       mem_q_reg;
    logic             byp_reg;
    logic [7:0]       byp_byte_reg;

    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_byte_reg;
    logic             m_last_reg;
    logic             m_unknown_reg;

    logic             a_fire;
    logic [7:0]       above, left, upleft, pred, result;
    logic [9:0]       p_base, d_left, d_above, d_upleft;
    logic [8:0]       avg_sum;

    assign a_fire = a_valid_reg && (!m_valid_reg || m_ready);
    assign pop    = q_valid && (!a_valid_reg || a_fire);

    // Above byte: zero on the first row; forwarded when the previous beat
    // wrote the same column in the cycle this one read it.
    assign above  = a_ctl_reg.first_row ? 8'd0 : (byp_reg ? byp_byte_reg : mem_q_reg);
    assign left   = a_ctl_reg.first_pixel ? 8'd0 : left_hist_reg[hist_idx];
    assign upleft = a_ctl_reg.first_pixel ? 8'd0 : upleft_hist_reg[hist_idx];

    assign avg_sum = {1'b0, left} + {1'b0, above};

    always_comb begin
        p_base   = {2'b00, left} + {2'b00, above} - {2'b00, upleft};
        d_left   = $signed(p_base) >= $signed({2'b00, left})
                 ? p_base - {2'b00, left} : {2'b00, left} - p_base;
        d_above  = $signed(p_base) >= $signed({2'b00, above})
                 ? p_base - {2'b00, above} : {2'b00, above} - p_base;
        d_upleft = $signed(p_base) >= $signed({2'b00, upleft})
                 ? p_base - {2'b00, upleft} : {2'b00, upleft} - p_base;
        if (d_left <= d_above && d_left <= d_upleft) begin
            pred = left;
        end else if (d_above <= d_upleft) begin
            pred = above;
        end else begin
            pred = upleft;
        end
    end

    always_comb begin
        case (a_ctl_reg.filt)
            FILT_SUB:   result = a_byte_reg + left;
            FILT_UP:    result = a_byte_reg + above;
            FILT_AVG:   result = a_byte_reg + avg_sum[8:1];
            FILT_PAETH: result = a_byte_reg + pred;
            default:    result = a_byte_reg;
        endcase
    end

    always_comb begin
        a_valid_next = a_valid_reg;
        if (pop) begin
            a_valid_next = 1'b1;
        end else if (a_fire) begin
            a_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (a_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Row memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (a_fire) begin
            row_mem[a_pos_reg] <= result;
        end
        if (pop) begin
            mem_q_reg <= row_mem[q_pos];
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            a_ctl_reg    <= q_ctl;
            a_byte_reg   <= q_byte;
            a_pos_reg    <= q_pos;
            byp_byte_reg <= result;
        end
        if (a_fire) begin
            for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
                left_hist_reg[k]   <= left_hist_reg[k-1];
                upleft_hist_reg[k] <= upleft_hist_reg[k-1];
            end
            left_hist_reg[0]   <= result;
            upleft_hist_reg[0] <= above;
            m_byte_reg         <= result;
            m_last_reg         <= a_ctl_reg.last;
            m_unknown_reg      <= (a_ctl_reg.filt == FILT_UNKNOWN);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            byp_reg     <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            m_valid_reg <= m_valid_next;
            if (pop) begin
                byp_reg <= a_fire && (a_pos_reg == q_pos);
            end else if (a_fire) begin
                byp_reg <= 1'b0;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_out_byte       = m_byte_reg;
    assign m_row_last       = m_last_reg;
    assign m_filter_unknown = m_unknown_reg;

`ifndef NO_ASSERTIONS
    a_fire_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        a_fire |=> m_valid_reg)
        else $error("computed beat did not reach output register");

    a_bypass_has_item: assert property (@(posedge aclk) disable iff (!aresetn)
        byp_reg |-> a_valid_reg)
        else $error("bypass flag set with no item in stage");

    a_bypass_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && a_fire && (a_pos_reg == q_pos) |=> byp_reg)
        else $error("same-column write not forwarded");
`endif

endmodule

// ===== rtl/png_row_unfilter.sv =====
// Top level of the PNG row unfilter: config registers, geometry, front/queue/back.
//
//  channel | ports                                             | direction
//  --------+---------------------------------------------------+----------
//  input   | s_valid s_ready s_data_byte s_stream_start        | in
//  result  | m_valid m_ready m_out_byte m_row_last             | out
//          |   m_filter_unknown                                |
//  config  | cfg_valid cfg_ready cfg_index cfg_data            | in
//
// One byte per cycle sustained unless a config hold or a stalled output
// holds it. Filter-type beats give no result; a row byte's result passes
// the queue, memory read stage and output register. Throughput is set by
// the single-port-write row memory and left-byte feedback, each once per cycle.
// Reset is synchronous, active low; the row memory is not cleared.
// A config beat holds s_ready low in its own cycle and while the settle
// counter runs down after it, as row length and bytes per pixel are
// recomputed; the same hold follows reset. A stalled output backs up
// through a 4-entry queue before s_ready drops.
module png_row_unfilter
    import pru_pkg::*;
#(
    parameter int MAX_ROW_BYTES   = 8192,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_stream_start,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_row_last,
    output logic        m_filter_unknown,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [13:0] cfg_data
);

    localparam int POS_W  = $clog2(MAX_ROW_BYTES);
    localparam int LEN_W  = $clog2(MAX_ROW_BYTES + 1);
    localparam int BPP_W  = $clog2(MAX_PIXEL_BYTES + 1);
    localparam int PB_W   = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int CTL_W  = $bits(item_ctl_t);
    localparam int QDATA_W = CTL_W + 8 + POS_W;

    localparam logic [1:0] SETTLE_CYCLES      = 2'd2;

    // Config registers
    logic [13:0] pixel_columns_reg;
    logic [2:0]  color_count_reg;
    logic [4:0]  component_bits_reg;
    logic [1:0]  settle_reg;

    // Geometry pipeline: bits per pixel, then bits per row
    logic [7:0]  pixel_bits_reg;
    logic [21:0] row_bits_reg;
    logic [22:0] row_bits_round;
    logic [19:0] row_bytes_raw;
    logic [4:0]  pixel_bytes_raw;
    logic [LEN_W-1:0] row_len;
    logic [BPP_W-1:0] pixel_bytes;
    logic [PB_W-1:0]  hist_idx;
    logic        cfg_write;
    logic        hold;

    // Front / queue / back links
    logic             push;
    logic [7:0]       push_byte;
    logic [POS_W-1:0] push_pos;
    item_ctl_t        push_ctl;
    logic [QDATA_W-1:0] q_head;
    logic             q_not_empty;
    logic             q_full;
    logic             pop;
    item_ctl_t        head_ctl;
    logic [7:0]       head_byte;
    logic [POS_W-1:0] head_pos;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign hold      = (settle_reg != 2'd0) || cfg_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_columns_reg  <= 14'd1;
            color_count_reg    <= 3'd1;
            component_bits_reg <= 5'd8;
            settle_reg         <= SETTLE_CYCLES;
        end else begin
            if (cfg_write) begin
                case (cfg_index)
                    REG_PIXEL_COLUMNS:  pixel_columns_reg  <= cfg_data;
                    REG_COLOR_COUNT:    color_count_reg    <= cfg_data[2:0];
                    REG_COMPONENT_BITS: component_bits_reg <= cfg_data[4:0];
                    default:            ;
                endcase
                settle_reg <= SETTLE_CYCLES;
            end else if (settle_reg != 2'd0) begin
                settle_reg <= settle_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pixel_bits_reg <= {5'd0, color_count_reg} * {3'd0, component_bits_reg};
        row_bits_reg   <= {8'd0, pixel_columns_reg} * {14'd0, pixel_bits_reg};
    end

    // Row length rounds up to whole bytes and saturates at the store size
    assign row_bits_round = {1'b0, row_bits_reg} + 23'd7;
    assign row_bytes_raw  = row_bits_round[22:3];
    assign row_len = (row_bytes_raw > 20'(MAX_ROW_BYTES))
                   ? LEN_W'(MAX_ROW_BYTES) : row_bytes_raw[LEN_W-1:0];

    // Sub-byte pixels still step one byte back
    assign pixel_bytes_raw = pixel_bits_reg[7:3];
    always_comb begin
        if (pixel_bytes_raw == 5'd0) begin
            pixel_bytes = BPP_W'(1);
        end else if (pixel_bytes_raw > 5'(MAX_PIXEL_BYTES)) begin
            pixel_bytes = BPP_W'(MAX_PIXEL_BYTES);
        end else begin
            pixel_bytes = pixel_bytes_raw[BPP_W-1:0];
        end
    end
    assign hist_idx = PB_W'(pixel_bytes - BPP_W'(1));

    pru_front #(
        .POS_W (POS_W),
        .LEN_W (LEN_W),
        .BPP_W (BPP_W)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_stream_start (s_stream_start),
        .row_len        (row_len),
        .pixel_bytes    (pixel_bytes),
        .hold           (hold),
        .q_full         (q_full),
        .push           (push),
        .push_byte      (push_byte),
        .push_pos       (push_pos),
        .push_ctl       (push_ctl)
    );

    pru_queue #(
        .DATA_W (QDATA_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({push_ctl, push_byte, push_pos}),
        .pop       (pop),
        .head_data (q_head),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    assign head_ctl  = q_head[QDATA_W-1 -: CTL_W];
    assign head_byte = q_head[POS_W +: 8];
    assign head_pos  = q_head[POS_W-1:0];

    pru_back #(
        .MAX_ROW_BYTES   (MAX_ROW_BYTES),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
        .POS_W           (POS_W),
        .PB_W            (PB_W)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (q_not_empty),
        .q_byte           (head_byte),
        .q_pos            (head_pos),
        .q_ctl            (head_ctl),
        .pop              (pop),
        .hist_idx         (hist_idx),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_row_last       (m_row_last),
        .m_filter_unknown (m_filter_unknown)
    );

endmodule

// ===== test/png_row_unfilter_tb.sv =====
// Self-checking testbench for png_row_unfilter: random streams checked against a local predictor.
`timescale 1ns / 100ps

module png_row_unfilter_tb
    import pru_pkg::*;
;

    localparam int ROW_STORE_BYTES = 8192;
    localparam int PIXEL_HIST      = 8;
    localparam int RANDOM_BEATS    = 1600;
    localparam int SETTLE_CYCLES   = 8;    // covers the result path plus the config hold
    localparam int STALL_LIMIT     = 1000; // cycles with no beat on any channel
    localparam int MAX_REPORTS     = 100;

    localparam logic [1:0] REG_UNUSED         = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       drain_first;   // hold this beat until every owed byte is back
    } stream_beat_t;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       unknown;
    } rebuilt_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [13:0] data;
    } reg_write_t;

    // DUT ports; every input starts at a known value
    logic        aclk;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte    = 8'h00;
    logic        s_stream_start = 1'b0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_row_last;
    logic        m_filter_unknown;
    logic        cfg_valid      = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index      = 2'd0;
    logic [13:0] cfg_data       = 14'd0;

    png_row_unfilter #(
        .MAX_ROW_BYTES   (ROW_STORE_BYTES),
        .MAX_PIXEL_BYTES (PIXEL_HIST)
    ) uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_stream_start   (s_stream_start),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_row_last       (m_row_last),
        .m_filter_unknown (m_filter_unknown),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor state: our own copy of geometry regs and row history
    // ------------------------------------------------------------------
    logic [13:0] cols_reg;
    logic [2:0]  colors_reg;
    logic [4:0]  bits_reg;
    logic [7:0]  above_row   [ROW_STORE_BYTES];
    logic [7:0]  left_hist   [PIXEL_HIST];
    logic [7:0]  upleft_hist [PIXEL_HIST];
    int          col_pos;
    logic [7:0]  row_filter;
    bit          want_filter;
    bit          first_row;

    stream_beat_t stream_bytes [$];   // beats waiting to go out
    rebuilt_t     rebuilt_bytes [$];  // reconstructed bytes not yet seen on m_
    reg_write_t   cfg_writes [$];

    // Owed/seen counters are NBA-updated so either side reads pre-edge values
    int results_owed = 0;
    int results_seen = 0;
    int quiet_cycles = 0;
    int fault_count  = 0;
    int report_count = 0;
    int beats_queued = 0;
    bit idle_on      = 1'b1;

    // Row bytes: ceil(cols*colors*bits/8), clipped to the row store
    function automatic int row_length(input int cols, input int colors, input int bits);
        int n;
        n = (cols * colors * bits + 7) / 8;
        return (n > ROW_STORE_BYTES) ? ROW_STORE_BYTES : n;
    endfunction

    // Byte stride between a byte and its left neighbor, 1..8
    function automatic int pixel_length(input int colors, input int bits);
        int n;
        n = (colors * bits) / 8;
        if (n < 1) n = 1;
        return (n > PIXEL_HIST) ? PIXEL_HIST : n;
    endfunction

    function automatic int abs_diff(input int a, input int b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic void reset_model();
        int k;
        cols_reg    = 14'd1;
        colors_reg  = 3'd1;
        bits_reg    = 5'd8;
        for (k = 0; k < ROW_STORE_BYTES; k++) above_row[k] = 8'h00;
        for (k = 0; k < PIXEL_HIST; k++) begin
            left_hist[k]   = 8'h00;
            upleft_hist[k] = 8'h00;
        end
        col_pos     = 0;
        row_filter  = PNG_FILTER_NONE;
        want_filter = 1'b1;
        first_row   = 1'b1;
    endfunction

    function automatic void store_register(input logic [1:0] index, input logic [13:0] data);
        case (index)
            REG_PIXEL_COLUMNS:  cols_reg   = data;
            REG_COLOR_COUNT:    colors_reg = data[2:0];
            REG_COMPONENT_BITS: bits_reg   = data[4:0];
            default: ;
        endcase
    endfunction

    // Takes one accepted beat; returns 1 and queues the rebuilt byte if it is a row byte
    function automatic bit unfilter_byte(input logic [7:0] cur, input logic start);
        int         len, bpp, pos, base, dl, da, du, k;
        logic [7:0] left, above, upleft, pred, value;
        bit         last;
        rebuilt_t   r;

        len = row_length(cols_reg, colors_reg, bits_reg);
        bpp = pixel_length(colors_reg, bits_reg);
        if (start) begin
            first_row   = 1'b1;
            want_filter = 1'b1;
        end
        // Filter-type byte; with a zero row length every byte lands here
        if (want_filter || len == 0) begin
            row_filter  = cur;
            col_pos     = 0;
            want_filter = (len == 0);
            return 1'b0;
        end

        pos   = col_pos % ROW_STORE_BYTES;
        above = first_row ? 8'h00 : above_row[pos];
        if (pos >= bpp) begin
            left   = left_hist[bpp-1];
            upleft = upleft_hist[bpp-1];
        end else begin
            left   = 8'h00;
            upleft = 8'h00;
        end

        case (row_filter)
            PNG_FILTER_SUB:   pred = left;
            PNG_FILTER_UP:    pred = above;
            PNG_FILTER_AVG:   pred = 8'((int'(left) + int'(above)) >> 1);
            PNG_FILTER_PAETH: begin
                base = int'(left) + int'(above) - int'(upleft);
                dl   = abs_diff(base, int'(left));
                da   = abs_diff(base, int'(above));
                du   = abs_diff(base, int'(upleft));
                // ties favor left, then above
                if (dl <= da && dl <= du) pred = left;
                else if (da <= du)        pred = above;
                else                      pred = upleft;
            end
            default:          pred = 8'h00;   // none, or unknown type passes through
        endcase
        value = cur + pred;

        for (k = PIXEL_HIST - 1; k > 0; k--) begin
            left_hist[k]   = left_hist[k-1];
            upleft_hist[k] = upleft_hist[k-1];
        end
        left_hist[0]   = value;
        upleft_hist[0] = above;
        above_row[pos] = value;

        // Compared against the live length, so a mid-row shrink ends the row here
        last = (pos + 1 >= len);
        if (last) begin
            want_filter = 1'b1;
            first_row   = 1'b0;
            col_pos     = 0;
        end else begin
            col_pos = pos + 1;
        end

        r.value   = value;
        r.last    = last;
        r.unknown = (row_filter > PNG_FILTER_PAETH);
        rebuilt_bytes.insert(rebuilt_bytes.size(), r);
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Source driver: one beat per item, random gap before each
    // ------------------------------------------------------------------
    int           send_gap = 0;
    bit           took_beat;
    stream_beat_t next_beat;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap = 0;
        end else begin
            took_beat = s_valid && s_ready;
            if (took_beat) begin
                if (unfilter_byte(s_data_byte, s_stream_start))
                    results_owed <= results_owed + 1;
                send_gap = idle_on ? $urandom_range(0, 5) : 0;
            end
            // valid stays put until taken
            if (!s_valid || took_beat) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (stream_bytes.size() != 0 &&
                             (!stream_bytes[0].drain_first ||
                              (!took_beat && results_owed == results_seen))) begin
                    next_beat      = stream_bytes.pop_front();
                    s_valid        <= 1'b1;
                    s_data_byte    <= next_beat.data;
                    s_stream_start <= next_beat.start;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sink monitor: random back-pressure, in-order field compare
    // ------------------------------------------------------------------
    int       recv_wait = 0;
    rebuilt_t want;

    task automatic note_mismatch(input string field, input logic [7:0] exp_v,
                                 input logic [7:0] act_v);
        fault_count++;
        if (report_count < MAX_REPORTS) begin
            report_count++;
            $display("%0t ns: %s mismatch, expected %02h, got %02h", $time, field, exp_v, act_v);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            recv_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (rebuilt_bytes.size() == 0) begin
                    fault_count++;
                    if (report_count < MAX_REPORTS) begin
                        report_count++;
                        $display("%0t ns: unexpected beat, expected none, got %02h last=%b unk=%b",
                                 $time, m_out_byte, m_row_last, m_filter_unknown);
                    end
                end else begin
                    want = rebuilt_bytes.pop_front();
                    if (m_out_byte !== want.value)
                        note_mismatch("out_byte", want.value, m_out_byte);
                    if (m_row_last !== want.last)
                        note_mismatch("row_last", 8'(want.last), 8'(m_row_last));
                    if (m_filter_unknown !== want.unknown)
                        note_mismatch("filter_unknown", 8'(want.unknown), 8'(m_filter_unknown));
                end
                recv_wait = idle_on ? $urandom_range(0, 5) : 0;
            end
            if (recv_wait > 0) begin
                recv_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: any beat on any channel restarts the count
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("** png_row_unfilter: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_byte(input logic [7:0] data, input logic start, input logic drain);
        stream_beat_t b;
        b.data        = data;
        b.start       = start;
        b.drain_first = drain;
        stream_bytes.insert(stream_bytes.size(), b);
        beats_queued++;
    endtask

    // Filter byte followed by n fixed row bytes, most significant first
    task automatic queue_fixed_row(input logic [7:0] filt, input logic start,
                                   input logic [31:0] bytes, input int n);
        int k;
        queue_byte(filt, start, 1'b0);
        for (k = n - 1; k >= 0; k--) queue_byte(bytes[8*k +: 8], 1'b0, 1'b0);
    endtask

    function automatic logic [7:0] pick_filter();
        if ($urandom_range(0, 99) < 85) return 8'($urandom_range(0, 4));
        return 8'($urandom_range(5, 255));
    endfunction

    // Filter byte then n row bytes; now and then a stream restart lands mid-row
    task automatic queue_random_row(input logic start, input int n);
        int k;
        queue_byte(pick_filter(), start, $urandom_range(0, 49) == 0);
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 3)
                queue_byte(8'($urandom_range(0, 7)), 1'b1, 1'b0);
            else
                queue_byte(8'($urandom), 1'b0, $urandom_range(0, 99) == 0);
        end
    endtask

    // Drive all pending register writes; block must be idle. Ends on a falling edge.
    task automatic flush_cfg();
        reg_write_t w;
        while (cfg_writes.size() != 0) begin
            w = cfg_writes.pop_front();
            cfg_valid <= 1'b1;
            cfg_index <= w.index;
            cfg_data  <= w.data;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            store_register(w.index, w.data);
        end
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_geometry(input int cols, input int colors, input int bits);
        cfg_writes.insert(cfg_writes.size(), {REG_PIXEL_COLUMNS, 14'(cols)});
        cfg_writes.insert(cfg_writes.size(), {REG_COLOR_COUNT, 14'(colors)});
        cfg_writes.insert(cfg_writes.size(), {REG_COMPONENT_BITS, 14'(bits)});
        flush_cfg();
    endtask

    // Wait for every beat to go out and every owed byte to come back,
    // then give a trailing filter byte time to clear the pipe
    task automatic settle();
        do @(negedge aclk);
        while (!(stream_bytes.size() == 0 && !s_valid && results_owed == results_seen));
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int pc, cc, cb, len, rows, r, n, phase_start;
        bit big;

        reset_model();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset geometry: one-byte rows, one-byte pixels
        queue_fixed_row(PNG_FILTER_NONE,  1'b1, 32'h0000_00FF, 1);
        queue_fixed_row(PNG_FILTER_UP,    1'b0, 32'h0000_0001, 1);   // wraps to zero
        queue_fixed_row(PNG_FILTER_PAETH, 1'b0, 32'h0000_0080, 1);
        settle();

        // 4-byte rows, 2-byte pixels: every filter with extreme bytes
        cfg_writes.insert(cfg_writes.size(), {REG_UNUSED, 14'h3FFF});   // no such register
        set_geometry(2, 1, 16);
        queue_fixed_row(PNG_FILTER_NONE,  1'b1, 32'hFFFE_0001, 4);
        queue_fixed_row(PNG_FILTER_SUB,   1'b0, 32'hFFFF_FFFF, 4);
        queue_fixed_row(PNG_FILTER_UP,    1'b0, 32'h0102_FF80, 4);
        queue_fixed_row(PNG_FILTER_AVG,   1'b0, 32'hFFFF_FFFF, 4);
        queue_fixed_row(PNG_FILTER_PAETH, 1'b0, 32'h00FF_7F80, 4);
        queue_fixed_row(8'hFF,            1'b0, 32'hAA55_00FF, 4);   // unknown type
        settle();

        // Zero row length: every byte is eaten as a filter byte
        set_geometry(2, 0, 16);
        queue_byte(PNG_FILTER_SUB, 1'b1, 1'b0);
        queue_byte(8'h5A, 1'b0, 1'b0);
        settle();
        set_geometry(0, 1, 16);
        queue_byte(8'hA5, 1'b0, 1'b0);
        queue_byte(PNG_FILTER_UP, 1'b1, 1'b0);
        settle();

        // Largest field values: length clips to the store, stride to 8.
        // Then shrink below the current position while still on the first row.
        set_geometry(16383, 7, 31);
        queue_byte(PNG_FILTER_PAETH, 1'b1, 1'b0);
        repeat (12) queue_byte(8'($urandom), 1'b0, 1'b0);
        settle();
        set_geometry(5, 1, 8);
        queue_byte(8'h33, 1'b0, 1'b0);                   // closes the row at once
        queue_fixed_row(PNG_FILTER_UP, 1'b0, 32'h8090_A0B0, 4);
        queue_byte(8'hC0, 1'b0, 1'b0);
        settle();

        // Grow mid-row (first row), through the max legal geometry
        set_geometry(3, 1, 8);
        queue_fixed_row(PNG_FILTER_SUB, 1'b1, 32'h0000_0011, 1);
        settle();
        set_geometry(8192, 4, 16);
        queue_byte(8'h22, 1'b0, 1'b0);
        queue_byte(8'h44, 1'b0, 1'b0);
        queue_byte(8'h88, 1'b0, 1'b0);
        settle();
        set_geometry(6, 1, 8);
        queue_byte(8'hF0, 1'b0, 1'b0);
        queue_byte(8'h0F, 1'b0, 1'b0);                   // sixth byte ends the row
        queue_fixed_row(PNG_FILTER_AVG, 1'b0, 32'hFF01_FE02, 4);
        queue_byte(8'h7F, 1'b0, 1'b0);
        queue_byte(8'h80, 1'b0, 1'b0);
        settle();

        // Random phases: fresh geometry, fresh stream, a handful of rows each.
        // Every phase opens with a stream start so no stale row is ever read.
        phase_start = beats_queued;
        while (beats_queued - phase_start < RANDOM_BEATS) begin
            big = ($urandom_range(0, 7) == 0);
            do begin
                cb  = ($urandom_range(0, 19) != 0) ? (1 << $urandom_range(0, 4))
                                                    : $urandom_range(1, 31);
                cc  = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 4) : $urandom_range(1, 7);
                pc  = $urandom_range(1, big ? 300 : 24);
                len = row_length(pc, cc, cb);
            end while (len > (big ? 600 : 48));
            set_geometry(pc, cc, cb);
            idle_on = ($urandom_range(0, 3) != 0);   // some phases run back to back
            rows    = big ? $urandom_range(1, 3) : $urandom_range(2, 12);
            for (r = 0; r < rows && beats_queued - phase_start < RANDOM_BEATS; r++) begin
                n = len;
                if (r == rows - 1 && $urandom_range(0, 9) == 0)
                    n = $urandom_range(0, len - 1);    // leave the last row open
                queue_random_row(r == 0, n);
            end
            settle();
        end

        if (rebuilt_bytes.size() != 0) begin
            fault_count++;
            $display("%0t ns: %0d rebuilt bytes never arrived", $time, rebuilt_bytes.size());
        end

        if (fault_count == 0) begin
            $display("** png_row_unfilter: PASSED **");
        end else begin
            $display("** png_row_unfilter: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/pru_pkg.sv
rtl/pru_front.sv
rtl/pru_queue.sv
rtl/pru_back.sv
rtl/png_row_unfilter.sv
test/png_row_unfilter_tb.sv
